/* rtl/omni_pkg.sv */
// Shared types, constants and the quarter-wave sine table of the omni drive mixer.
// No dependencies; imported by every module of the block.
package omni_pkg;

  localparam int SINE_DEPTH = 256;
  localparam int SINE_AW    = $clog2(SINE_DEPTH + 1);
  localparam int DASH_GAIN  = 100663;  // round(0.006 * 2^24)
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // operation codes
  localparam logic [2:0] OP_STOP   = 3'd0;
  localparam logic [2:0] OP_TURN   = 3'd1;
  localparam logic [2:0] OP_DASH   = 3'd2;
  localparam logic [2:0] OP_SKICK  = 3'd3;
  localparam logic [2:0] OP_KICK   = 3'd4;
  localparam logic [2:0] OP_CATCH  = 3'd5;
  localparam logic [2:0] OP_SETVEL = 3'd6;
  localparam logic [2:0] OP_NONE   = 3'd7;

  // register indexes
  localparam logic [2:0] REG_COS_FRONT = 3'd0;
  localparam logic [2:0] REG_SIN_FRONT = 3'd1;
  localparam logic [2:0] REG_COS_BACK  = 3'd2;
  localparam logic [2:0] REG_SIN_BACK  = 3'd3;
  localparam logic [2:0] REG_INV_RAD   = 3'd4;
  localparam logic [2:0] REG_RATIO     = 3'd5;

  // sequencer steps
  localparam logic [4:0] STEP_DASH  = 5'd0;
  localparam logic [4:0] STEP_WHEEL = 5'd4;
  localparam logic [4:0] STEP_LAST  = 5'd23;

  typedef enum logic [2:0] {
    MUL_PWR, MUL_ASIN, MUL_ACOS, MUL_WR, MUL_UC, MUL_VC, MUL_LINR
  } mul_sel_e;

  typedef enum logic [1:0] {
    LIN_HOLD, LIN_LOAD, LIN_ADD
  } lin_op_e;

  typedef struct packed {
    logic       load;
    logic       save_a;
    logic       add_u;
    logic       add_v;
    logic       save_wr;
    logic       dec_start;
    mul_sel_e   mul_sel;
    logic [1:0] mul_wheel;
    lin_op_e    lin_op;
    logic       q24;
    logic       scale;
    logic       fin;
    logic [1:0] fin_wheel;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic        [2:0]  operation;
    logic signed [15:0] power;
    logic        [15:0] direction;
    logic signed [31:0] target_u;
    logic signed [31:0] target_v;
    logic signed [31:0] target_w;
    logic               kicker_ready;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] wheel_front_right;
    logic signed [15:0] wheel_back_right;
    logic signed [15:0] wheel_back_left;
    logic signed [15:0] wheel_front_left;
    logic signed [7:0]  dribbler_drive;
    logic               kick_fire;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] cos_front;
    logic signed [15:0] sin_front;
    logic signed [15:0] cos_back;
    logic signed [15:0] sin_back;
    logic        [15:0] inv_wheel_radius;
    logic        [15:0] body_to_wheel_ratio;
  } cfg_t;

  typedef logic [14:0] sine_rom_t [SINE_DEPTH + 1];

  // sin(pi/2 * k / depth) in Q1.14, Taylor series to x^11 in Q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic        [63:0] x;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      if (k == SINE_DEPTH) begin
        rom[k] = 15'd16384;
      end else begin
        x    = HALF_PI_Q30 * 64'(k) / 64'(SINE_DEPTH);
        x2   = (x * x) >> 30;
        sum  = $signed(x);
        term = ((x * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        if (sum < 0) begin
          sum = 64'sd0;
        end
        rom[k] = 15'((64'(sum) + 64'd32768) >> 16);
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* rtl/omni_regs.sv */
// APB-style configuration registers of the omni drive mixer.
// Depends on omni_pkg for the register indexes and cfg_t.
module omni_regs import omni_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_front           <= 16'sd11585;
      cfg_q.sin_front           <= 16'sd11585;
      cfg_q.cos_back            <= 16'sd11585;
      cfg_q.sin_back            <= 16'sd11585;
      cfg_q.inv_wheel_radius    <= 16'd8192;
      cfg_q.body_to_wheel_ratio <= 16'd1280;
    end else if (wr) begin
      case (idx)
        REG_COS_FRONT: cfg_q.cos_front           <= pwdata[15:0];
        REG_SIN_FRONT: cfg_q.sin_front           <= pwdata[15:0];
        REG_COS_BACK:  cfg_q.cos_back            <= pwdata[15:0];
        REG_SIN_BACK:  cfg_q.sin_back            <= pwdata[15:0];
        REG_INV_RAD:   cfg_q.inv_wheel_radius    <= pwdata[15:0];
        REG_RATIO:     cfg_q.body_to_wheel_ratio <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COS_FRONT: prdata = {16'd0, cfg_q.cos_front};
      REG_SIN_FRONT: prdata = {16'd0, cfg_q.sin_front};
      REG_COS_BACK:  prdata = {16'd0, cfg_q.cos_back};
      REG_SIN_BACK:  prdata = {16'd0, cfg_q.sin_back};
      REG_INV_RAD:   prdata = {16'd0, cfg_q.inv_wheel_radius};
      REG_RATIO:     prdata = {16'd0, cfg_q.body_to_wheel_ratio};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/omni_ctrl.sv */
// Sequencer of the omni drive mixer: handshakes and the step schedule of the datapath.
// Depends on omni_pkg for cmd_t, step and operation codes.
module omni_ctrl import omni_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] in_op_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output cmd_t       cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic [4:0] sa, sb;
  cmd_t       cmd;

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_WR;
    cmd.lin_op  = LIN_HOLD;
    sa          = step_q - 5'd5;
    sb          = step_q - 5'd9;
    accept      = (state_q == S_IDLE) && in_valid_i;
    cmd.load    = accept && (in_op_i != OP_NONE);
    if (state_q == S_RUN) begin
      case (step_q)
        5'd0: cmd.mul_sel = MUL_PWR;
        5'd1: begin
          cmd.mul_sel = MUL_ASIN;
          cmd.save_a  = 1'b1;
        end
        5'd2: begin
          cmd.mul_sel = MUL_ACOS;
          cmd.add_u   = 1'b1;
        end
        5'd3: cmd.add_v = 1'b1;
        5'd4: begin
          cmd.mul_sel   = MUL_WR;
          cmd.dec_start = 1'b1;
        end
        default: ;
      endcase
      cmd.save_wr = (step_q == 5'd5);
      // four wheels overlap: products of one, tail of the previous
      if (step_q inside {[5'd5:5'd20]}) begin
        cmd.mul_wheel = sa[3:2];
        case (sa[1:0])
          2'd0: cmd.mul_sel = MUL_UC;
          2'd1: begin
            cmd.mul_sel = MUL_VC;
            cmd.lin_op  = LIN_LOAD;
          end
          2'd2: cmd.lin_op = LIN_ADD;
          default: cmd.mul_sel = MUL_LINR;
        endcase
      end
      if (step_q inside {[5'd9:5'd23]}) begin
        cmd.fin_wheel = sb[3:2];
        case (sb[1:0])
          2'd0: cmd.q24   = 1'b1;
          2'd1: cmd.scale = 1'b1;
          2'd2: cmd.fin   = 1'b1;
          default: ;
        endcase
      end
    end
    cmd.commit = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (cmd.load) begin
          state_d = S_RUN;
          step_d  = (in_op_i == OP_DASH) ? STEP_DASH : STEP_WHEEL;
        end
      end
      S_RUN: begin
        step_d = step_q + 5'd1;
        if (step_q == STEP_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd.commit) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* rtl/omni_dp.sv */
// Datapath of the omni drive mixer: body state, shared multiplier, wheel mixing, decay divider.
// Depends on omni_pkg for types, the sine table and operation codes.
module omni_dp import omni_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  in_item_t  in_data_i,
  input  cfg_t      cfg_i,
  output out_item_t out_data_o
);

  localparam logic [3:0] DIV_STEPS = 4'd9;

  logic signed [31:0] u_q, v_q, w_q;
  logic signed [7:0]  drib_q;
  logic               skick_q;
  logic               fire_q;
  logic signed [15:0] power_q, sin_q, cos_q;
  logic signed [33:0] a_q;
  logic signed [52:0] prod_q;
  logic signed [48:0] lin_q;
  logic signed [47:0] wr_q;
  logic signed [50:0] q24_q;
  logic signed [57:0] s_q;
  logic signed [15:0] wheel_q [4];
  out_item_t          out_q;
  logic        [35:0] dnu_q, dnv_q;
  logic        [2:0]  dru_q, drv_q;
  logic               dneg_u_q, dneg_v_q;
  logic        [3:0]  dcnt_q;

  logic signed [34:0] ma;
  logic signed [17:0] mb;
  logic signed [17:0] cu, cv;
  logic signed [48:0] lin_rnd;
  logic signed [34:0] linr;
  logic signed [52:0] dash_rnd;
  logic signed [33:0] sum_u, sum_v;
  logic signed [31:0] sat_sum;
  logic signed [16:0] npow;
  logic signed [16:0] drib_rnd;
  logic signed [7:0]  drib_sk;
  logic signed [57:0] q24x;
  logic signed [57:0] fin_rnd;
  logic signed [33:0] fin_val;
  logic signed [15:0] fin_sat;
  logic        [32:0] au, av;
  logic        [38:0] stp_u, stp_v;

  function automatic logic signed [15:0] sine_at(input logic [15:0] hd);
    logic [13+SINE_AW:0] kp;
    logic [SINE_AW-1:0]  k;
    logic [SINE_AW-1:0]  idx;
    logic [14:0]         t;
    kp  = (14 + SINE_AW)'(hd[13:0]) * (14 + SINE_AW)'(SINE_DEPTH);
    k   = kp[13+SINE_AW:14];
    idx = hd[14] ? (SINE_AW'(SINE_DEPTH) - k) : k;
    t   = SINE_ROM[idx];
    return hd[15] ? -$signed({1'b0, t}) : $signed({1'b0, t});
  endfunction

  // four restoring steps of a divide by five
  function automatic logic [38:0] div5_step(input logic [35:0] n_in, input logic [2:0] r_in);
    logic [35:0] n;
    logic [2:0]  r;
    logic [3:0]  r4;
    n = n_in;
    r = r_in;
    for (int i = 0; i < 4; i++) begin
      r4 = {r, n[35]};
      n  = {n[34:0], 1'b0};
      if (r4 >= 4'd5) begin
        r    = 3'(r4 - 4'd5);
        n[0] = 1'b1;
      end else begin
        r = r4[2:0];
      end
    end
    return {n, r};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if (x > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // wheel coefficients
  always_comb begin
    case (cmd_i.mul_wheel)
      2'd0: begin
        cu = -18'(cfg_i.sin_front);
        cv = -18'(cfg_i.cos_front);
      end
      2'd1: begin
        cu = 18'(cfg_i.sin_back);
        cv = -18'(cfg_i.cos_back);
      end
      2'd2: begin
        cu = 18'(cfg_i.sin_back);
        cv = 18'(cfg_i.cos_back);
      end
      default: begin
        cu = -18'(cfg_i.sin_front);
        cv = 18'(cfg_i.cos_front);
      end
    endcase
  end

  // round half away from zero: (x + half - neg) >>> s
  assign lin_rnd = lin_q + 49'sd8192 - 49'(lin_q[48]);
  assign linr    = lin_rnd[48:14];

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_PWR: begin
        ma = 35'(power_q);
        mb = 18'(DASH_GAIN);
      end
      MUL_ASIN: begin
        ma = $signed(prod_q[34:0]);
        mb = 18'(sin_q);
      end
      MUL_ACOS: begin
        ma = 35'(a_q);
        mb = 18'(cos_q);
      end
      MUL_UC: begin
        ma = 35'(u_q);
        mb = cu;
      end
      MUL_VC: begin
        ma = 35'(v_q);
        mb = cv;
      end
      MUL_LINR: begin
        ma = 35'(linr);
        mb = $signed({2'b00, cfg_i.inv_wheel_radius});
      end
      default: begin
        ma = 35'(w_q);
        mb = $signed({2'b00, cfg_i.body_to_wheel_ratio});
      end
    endcase
  end

  assign dash_rnd = (prod_q + 53'sd536870912 - 53'(prod_q[52])) >>> 30;
  assign sum_u    = 34'(u_q) + 34'($signed(dash_rnd[22:0]));
  assign sum_v    = 34'(v_q) + 34'($signed(dash_rnd[22:0]));
  assign sat_sum  = cmd_i.add_u ? sat32(sum_u) : sat32(sum_v);

  // short-kick dribbler level: round(-power / 256), saturated
  assign npow     = -17'(in_data_i.power);
  assign drib_rnd = (npow + 17'sd128 - $signed(17'(npow[16]))) >>> 8;
  always_comb begin
    if (drib_rnd > 17'sd127) begin
      drib_sk = 8'sd127;
    end else begin
      drib_sk = drib_rnd[7:0];
    end
  end

  assign q24x    = 58'(q24_q);
  assign fin_rnd = (s_q + 58'sd8388608 - 58'(s_q[57])) >>> 24;
  assign fin_val = fin_rnd[33:0];
  always_comb begin
    if (fin_val > 34'sd32767) begin
      fin_sat = 16'sh7FFF;
    end else if (fin_val < -34'sd32768) begin
      fin_sat = 16'sh8000;
    end else begin
      fin_sat = fin_val[15:0];
    end
  end

  assign au    = u_q[31] ? -33'(u_q) : 33'(u_q);
  assign av    = v_q[31] ? -33'(v_q) : 33'(v_q);
  assign stp_u = div5_step(dnu_q, dru_q);
  assign stp_v = div5_step(dnv_q, drv_q);

  // body state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q     <= '0;
      v_q     <= '0;
      w_q     <= '0;
      drib_q  <= '0;
      skick_q <= 1'b0;
      fire_q  <= 1'b0;
    end else if (cmd_i.load) begin
      fire_q <= (in_data_i.operation == OP_KICK) && in_data_i.kicker_ready;
      case (in_data_i.operation)
        OP_STOP: begin
          u_q    <= '0;
          v_q    <= '0;
          w_q    <= '0;
          drib_q <= '0;
        end
        OP_TURN: w_q <= in_data_i.target_w;
        OP_DASH: w_q <= '0;
        OP_SKICK: begin
          drib_q  <= drib_sk;
          skick_q <= 1'b1;
          w_q     <= '0;
        end
        OP_KICK: begin
          drib_q <= '0;
          w_q    <= '0;
        end
        OP_CATCH: begin
          drib_q <= 8'sd100;
          w_q    <= '0;
        end
        OP_SETVEL: begin
          u_q <= in_data_i.target_u;
          v_q <= in_data_i.target_v;
          w_q <= in_data_i.target_w;
        end
        default: ;
      endcase
    end else if (cmd_i.add_u) begin
      u_q <= sat_sum;
    end else if (cmd_i.add_v) begin
      v_q <= sat_sum;
    end else if (cmd_i.commit) begin
      u_q <= dneg_u_q ? -32'(dnu_q) : 32'(dnu_q);
      v_q <= dneg_v_q ? -32'(dnv_q) : 32'(dnv_q);
      if (skick_q) begin
        drib_q  <= '0;
        skick_q <= 1'b0;
      end
    end
  end

  // decay to 2x/5: quotient of (2|x| + 2) / 5
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.dec_start) begin
      dcnt_q <= DIV_STEPS;
    end else if (dcnt_q != 4'd0) begin
      dcnt_q <= dcnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec_start) begin
      dnu_q    <= ({3'b000, au} << 1) + 36'd2;
      dnv_q    <= ({3'b000, av} << 1) + 36'd2;
      dru_q    <= '0;
      drv_q    <= '0;
      dneg_u_q <= u_q[31];
      dneg_v_q <= v_q[31];
    end else if (dcnt_q != 4'd0) begin
      {dnu_q, dru_q} <= stp_u;
      {dnv_q, drv_q} <= stp_v;
    end
  end

  // arithmetic payload
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    if (cmd_i.load) begin
      power_q <= in_data_i.power;
      sin_q   <= sine_at(in_data_i.direction);
      cos_q   <= sine_at(in_data_i.direction + 16'd16384);
    end
    if (cmd_i.save_a) begin
      a_q <= prod_q[33:0];
    end
    if (cmd_i.save_wr) begin
      wr_q <= prod_q[47:0];
    end
    case (cmd_i.lin_op)
      LIN_LOAD: lin_q <= prod_q[48:0];
      LIN_ADD:  lin_q <= lin_q + prod_q[48:0];
      default: ;
    endcase
    if (cmd_i.q24) begin
      q24_q <= $signed(prod_q[50:0]) + 51'(wr_q);
    end
    if (cmd_i.scale) begin
      s_q <= (q24x <<< 6) + (q24x <<< 5) + (q24x <<< 2);
    end
    if (cmd_i.fin) begin
      wheel_q[cmd_i.fin_wheel] <= fin_sat;
    end
    if (cmd_i.commit) begin
      out_q.wheel_front_right <= wheel_q[0];
      out_q.wheel_back_right  <= wheel_q[1];
      out_q.wheel_back_left   <= wheel_q[2];
      out_q.wheel_front_left  <= wheel_q[3];
      out_q.dribbler_drive    <= drib_q;
      out_q.kick_fire         <= fire_q;
    end
  end

  assign out_data_o = out_q;

endmodule

/* rtl/omni_drive_command_mixer_unit.sv */
// One command at a time: the block stalls its input from accept until the result is
// committed, and a stalled output holds back the commit.
// The sequencer runs 24 or 20 steps for the shared 35x18 multiplier's 16 or 13 products.
// An unused operation code is accepted and gives no result.
// Reset (rst_ni, async, low) clears body velocity, dribbler, flags and loads register defaults.
// Top level: instantiates omni_regs, omni_ctrl and omni_dp; depends on omni_pkg.
module omni_drive_command_mixer_unit import omni_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  cmd_t cmd;

  assign pready = 1'b1;

  omni_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  omni_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.operation),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  omni_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .out_data_o (out_data_o)
  );

endmodule

/* rtl/omni_checker.sv */
// Port-level checks of the omni drive mixer, bound to the top level.
// Depends on omni_pkg for the item types and operation codes.
module omni_checker import omni_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_item_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_data_o,
  input logic        pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a real command keeps the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.operation != OP_NONE) |=> in_stall_o)
    else $error("command accepted without going busy");

  // a new result only comes out of a busy block
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a command in flight");

  // a kick stops the dribbler in the same frame
  a_kick_drib: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kick_fire |-> out_data_o.dribbler_drive == 8'sd0 && pready)
    else $error("kick frame with dribbler running");

endmodule

bind omni_drive_command_mixer_unit omni_checker u_checker (.*);
